### src/tdd_pkg.sv
// Shared types, symbol codes and helpers for the temperature display formatter.
// Used by tdd_split, tdd_format and temperature_to_display_digits.
`default_nettype none

package tdd_pkg;

   // Display symbol codes
   localparam logic [3:0] SYM_HYPHEN = 4'd10;

   // Decimal point position codes
   localparam logic [1:0] POINT_NONE         = 2'd0;
   localparam logic [1:0] POINT_AFTER_SECOND = 2'd1;
   localparam logic [1:0] POINT_AFTER_THIRD  = 2'd2;

   // Threshold register reset and the lowest value that can be shown
   localparam logic signed [15:0] THRESHOLD_RESET = 16'sd12600;
   localparam logic signed [15:0] TEMP_MIN_SHOWN  = -16'sd9999;
   localparam logic signed [15:0] TEMP_BIG        = 16'sd10000;
   localparam logic [14:0]        MAG_THOUSAND    = 15'd1000;

   // Decimal split of a 15-bit magnitude
   typedef struct packed {
      logic [1:0]  ten_thousands;  // m / 10000
      logic [3:0]  rem_thousands;  // (m / 1000) % 10
      logic [3:0]  rem_hundreds;   // (m / 100) % 10
      logic [3:0]  rem_tens;       // (m / 10) % 10
      logic [3:0]  rem_units;      // m % 10
      logic        at_least_1000;  // m >= 1000
   } split_type;

   // One formatted result
   typedef struct packed {
      logic [3:0] digit_first;
      logic [3:0] digit_second;
      logic [3:0] digit_third;
      logic [3:0] digit_fourth;
      logic [1:0] point_position;
      logic       error_flag;
   } result_type;

   // Remainder digit: the true value is 0..9, so four low bits suffice
   function automatic logic [3:0] digit_rem(input logic [3:0] num_lo,
                                            input logic [3:0] quo_lo);
      return 4'(num_lo - 4'(quo_lo * 4'd10));
   endfunction

endpackage

`default_nettype wire

### src/tdd_split.sv
// Decimal split of the temperature magnitude by reciprocal multiplication.
// Depends on tdd_pkg for split_type and digit_rem.
`default_nettype none

module tdd_split import tdd_pkg::*; (
   input  wire logic signed [15:0] temperature,
   output split_type               split
);

   logic [14:0] mag;
   logic [30:0] prod_10;
   logic [27:0] prod_100;
   logic [30:0] prod_1000;
   logic [11:0] quo_10;
   logic [8:0]  quo_100;
   logic [5:0]  quo_1000;
   logic [1:0]  quo_10000;

   // Magnitude; the most negative input wraps but is shown as an error anyway
   assign mag = temperature[15] ? 15'(-temperature) : temperature[14:0];

   // Quotients by constants, exact for magnitudes below 32768
   assign prod_10   = 31'(mag) * 31'd52429;
   assign prod_100  = 28'(mag) * 28'd5243;
   assign prod_1000 = 31'(mag) * 31'd33555;
   assign quo_10    = prod_10[30:19];
   assign quo_100   = prod_100[27:19];
   assign quo_1000  = prod_1000[30:25];

   // Leading digit is at most 3
   always_comb begin
      if (mag >= 15'd30000) begin
         quo_10000 = 2'd3;
      end else if (mag >= 15'd20000) begin
         quo_10000 = 2'd2;
      end else if (mag >= 15'd10000) begin
         quo_10000 = 2'd1;
      end else begin
         quo_10000 = 2'd0;
      end
   end

   // Remainders from low bits only
   assign split.ten_thousands = quo_10000;
   assign split.rem_thousands = digit_rem(quo_1000[3:0], {2'b00, quo_10000});
   assign split.rem_hundreds  = digit_rem(quo_100[3:0], quo_1000[3:0]);
   assign split.rem_tens      = digit_rem(quo_10[3:0], quo_100[3:0]);
   assign split.rem_units     = digit_rem(mag[3:0], quo_10[3:0]);
   assign split.at_least_1000 = (mag >= MAG_THOUSAND);

endmodule

`default_nettype wire

### src/tdd_format.sv
// Range check and symbol selection for one temperature.
// Depends on tdd_pkg for split_type, result_type and the symbol codes.
`default_nettype none

module tdd_format import tdd_pkg::*; (
   input  wire logic signed [15:0] temperature,
   input  wire logic signed [15:0] threshold,
   input  wire split_type          split,
   output result_type              result
);

   logic is_error;
   logic is_neg;
   logic is_big;

   assign is_error = (temperature >= threshold) || (temperature < TEMP_MIN_SHOWN);
   assign is_neg   = temperature[15];
   assign is_big   = !is_neg && (temperature >= TEMP_BIG);

   // Pick the symbols and point for the value's range
   always_comb begin
      if (is_error) begin
         result = '{SYM_HYPHEN, SYM_HYPHEN, SYM_HYPHEN, SYM_HYPHEN, POINT_NONE, 1'b1};
      end else if (is_neg && split.at_least_1000) begin
         result = '{SYM_HYPHEN, split.rem_thousands, split.rem_hundreds,
                    split.rem_tens, POINT_AFTER_THIRD, 1'b0};
      end else if (is_neg) begin
         result = '{SYM_HYPHEN, split.rem_hundreds, split.rem_tens,
                    split.rem_units, POINT_AFTER_SECOND, 1'b0};
      end else if (is_big) begin
         result = '{{2'b00, split.ten_thousands}, split.rem_thousands,
                    split.rem_hundreds, split.rem_tens, POINT_AFTER_THIRD, 1'b0};
      end else begin
         result = '{split.rem_thousands, split.rem_hundreds, split.rem_tens,
                    split.rem_units, POINT_AFTER_SECOND, 1'b0};
      end
   end

endmodule

`default_nettype wire

### src/temperature_to_display_digits.sv
// Top level: input register, decimal split and formatting, result register.
// Depends on tdd_pkg, tdd_split and tdd_format.
//
//   port group | direction | carries
//   req_       | in        | temperature_centi, one beat per conversion
//   rsp_       | out       | four symbols, point position, error flag
//   csr_       | in        | error_threshold write, no read-back
//
// One beat in per cycle while the result channel does not stall; an accepted beat is
// captured in the input register, then makes a single pass through the reciprocal
// multipliers and the symbol select into the result register.
// Synchronous active-high reset empties both registers and loads the
// threshold with 12600. A stalled result holds while the input register
// keeps accepting until it too is full.
`default_nettype none

module temperature_to_display_digits import tdd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [15:0] req_temperature_centi,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [3:0]  rsp_digit_first,
   output      logic [3:0]  rsp_digit_second,
   output      logic [3:0]  rsp_digit_third,
   output      logic [3:0]  rsp_digit_fourth,
   output      logic [1:0]  rsp_point_position,
   output      logic        rsp_error_flag,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic signed [15:0] threshold_ff;
   logic               in_valid_ff;
   logic signed [15:0] temp_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   result_type         rsp_in;
   split_type          split;
   logic               rsp_adv;
   logic               in_adv;

   // Advance each stage when its downstream has room
   assign rsp_adv   = !rsp_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || rsp_adv;
   assign req_stall = !in_adv;

   tdd_split u_split (
      .temperature (temp_ff),
      .split       (split)
   );

   tdd_format u_format (
      .temperature (temp_ff),
      .threshold   (threshold_ff),
      .split       (split),
      .result      (rsp_in)
   );

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         temp_ff <= req_temperature_centi;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit_first    = rsp_ff.digit_first;
   assign rsp_digit_second   = rsp_ff.digit_second;
   assign rsp_digit_third    = rsp_ff.digit_third;
   assign rsp_digit_fourth   = rsp_ff.digit_fourth;
   assign rsp_point_position = rsp_ff.point_position;
   assign rsp_error_flag     = rsp_ff.error_flag;

   // An error result shows only hyphens and no point
   a_error_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error_flag |->
         rsp_ff.digit_first == SYM_HYPHEN && rsp_ff.digit_fourth == SYM_HYPHEN &&
         rsp_ff.point_position == POINT_NONE)
      else $error("error result without hyphen pattern");

   // A good result always has a point and a decimal last digit
   a_good_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.error_flag |->
         (rsp_ff.point_position == POINT_AFTER_SECOND ||
          rsp_ff.point_position == POINT_AFTER_THIRD) && rsp_ff.digit_fourth <= 4'd9)
      else $error("good result with bad point or digit");

   // Stall only while the input register holds a beat
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled while empty");

   // A held beat that moves on shows up as a result next cycle
   a_beat_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_adv |=> rsp_valid_ff)
      else $error("beat lost between input and result register");

endmodule

`default_nettype wire

### tb/tb_temperature_to_display_digits.sv
// Self-checking testbench for temperature_to_display_digits: drives readings,
// predicts the display symbols, point position and error flag, and checks every result beat.
// Depends on tdd_pkg and the block's RTL only.

module tb_temperature_to_display_digits;
   import tdd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BEATS  = 180;
   localparam int NUM_PHASES   = 8;
   localparam int REPORT_LIMIT = 20;

   // Idle modes of the random phases
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   typedef struct {
      logic signed [15:0] temp;
      result_type         shown;
   } expected_reading_type;

   // Predicts the display for each accepted reading and checks result beats in order
   class display_scoreboard_type;
      int                   threshold;
      expected_reading_type pending_q[$];
      int                   mismatches;
      int                   checked;
      int                   error_patterns;

      function new();
         threshold      = THRESHOLD_RESET;
         mismatches     = 0;
         checked        = 0;
         error_patterns = 0;
      endfunction

      function result_type format_reading(logic signed [15:0] t);
         result_type r;
         int         tv;
         int         m;
         tv = t;
         if (tv >= threshold || tv < -9999) begin
            // error pattern: four hyphens, no point
            r.digit_first    = SYM_HYPHEN;
            r.digit_second   = SYM_HYPHEN;
            r.digit_third    = SYM_HYPHEN;
            r.digit_fourth   = SYM_HYPHEN;
            r.point_position = POINT_NONE;
            r.error_flag     = 1'b1;
         end else if (tv >= 0 && tv < 10000) begin
            m = tv;
            r.digit_first    = 4'(m / 1000);
            r.digit_second   = 4'((m / 100) % 10);
            r.digit_third    = 4'((m / 10) % 10);
            r.digit_fourth   = 4'(m % 10);
            r.point_position = POINT_AFTER_SECOND;
            r.error_flag     = 1'b0;
         end else if (tv >= 10000) begin
            // drop the hundredths
            m = tv;
            r.digit_first    = 4'(m / 10000);
            r.digit_second   = 4'((m / 1000) % 10);
            r.digit_third    = 4'((m / 100) % 10);
            r.digit_fourth   = 4'((m / 10) % 10);
            r.point_position = POINT_AFTER_THIRD;
            r.error_flag     = 1'b0;
         end else begin
            // leading hyphen, magnitude truncated toward zero
            m = -tv;
            r.digit_first = SYM_HYPHEN;
            if (m >= 1000) begin
               r.digit_second   = 4'(m / 1000);
               r.digit_third    = 4'((m / 100) % 10);
               r.digit_fourth   = 4'((m / 10) % 10);
               r.point_position = POINT_AFTER_THIRD;
            end else begin
               r.digit_second   = 4'(m / 100);
               r.digit_third    = 4'((m / 10) % 10);
               r.digit_fourth   = 4'(m % 10);
               r.point_position = POINT_AFTER_SECOND;
            end
            r.error_flag = 1'b0;
         end
         return r;
      endfunction

      function void note_reading(logic signed [15:0] t);
         expected_reading_type e;
         e.temp  = t;
         e.shown = format_reading(t);
         if (e.shown.error_flag) begin
            error_patterns++;
         end
         pending_q.push_back(e);
      endfunction

      task report(string msg);
         if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
         end
         mismatches++;
      endtask

      task compare_field(string name, int got, int want, logic signed [15:0] t);
         if (got != want) begin
            report($sformatf("temp %0d %s got %0d want %0d", t, name, got, want));
         end
      endtask

      task check_display(result_type got);
         expected_reading_type e;
         if (pending_q.size() == 0) begin
            report("result beat with no reading waiting");
         end else begin
            e = pending_q.pop_front();
            checked++;
            compare_field("digit_first", got.digit_first, e.shown.digit_first, e.temp);
            compare_field("digit_second", got.digit_second, e.shown.digit_second, e.temp);
            compare_field("digit_third", got.digit_third, e.shown.digit_third, e.temp);
            compare_field("digit_fourth", got.digit_fourth, e.shown.digit_fourth, e.temp);
            compare_field("point_position", got.point_position, e.shown.point_position,
                          e.temp);
            compare_field("error_flag", got.error_flag, e.shown.error_flag, e.temp);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_temperature_centi;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_digit_first;
   logic [3:0]  rsp_digit_second;
   logic [3:0]  rsp_digit_third;
   logic [3:0]  rsp_digit_fourth;
   logic [1:0]  rsp_point_position;
   logic        rsp_error_flag;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   display_scoreboard_type sb;
   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;

   temperature_to_display_digits dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_temperature_centi (req_temperature_centi),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_digit_first       (rsp_digit_first),
      .rsp_digit_second      (rsp_digit_second),
      .rsp_digit_third       (rsp_digit_third),
      .rsp_digit_fourth      (rsp_digit_fourth),
      .rsp_point_position    (rsp_point_position),
      .rsp_error_flag        (rsp_error_flag),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // Check each accepted result beat
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.digit_first    = rsp_digit_first;
         got.digit_second   = rsp_digit_second;
         got.digit_third    = rsp_digit_third;
         got.digit_fourth   = rsp_digit_fourth;
         got.point_position = rsp_point_position;
         got.error_flag     = rsp_error_flag;
         sb.check_display(got);
      end
   end

   // Offer one reading, idling first at random, and hold it until accepted
   task send_reading(logic [15:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_temperature_centi = t;
      do @(posedge clock); while (req_stall);
      sb.note_reading(t);
      @(negedge clock);
   endtask

   task wait_drained();
      while (sb.pending_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task write_threshold(int value);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = 16'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.threshold = int'($signed(16'(value)));
   endtask

   // Mostly the three display ranges, plus boundaries and raw 16-bit noise
   function automatic logic [15:0] pick_reading(int thr);
      int base;
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'($urandom_range(9999));
         4, 5: return 16'($urandom_range(32767, 10000));
         6, 7: return 16'(-int'($urandom_range(9999, 1)));
         8: return 16'($urandom);
         default: begin
            case ($urandom_range(4))
               0: base = thr;
               1: base = -10000;
               2: base = -1000;
               3: base = 10000;
               default: base = 0;
            endcase
            return 16'(base + int'($urandom_range(6)) - 3);
         end
      endcase
   endfunction

   task run_phase(int mode, int beats);
      for (int i = 0; i < beats; i++) begin
         // keep a quiet stretch at the start of every window
         if (i % 60 < 10 || mode == IDLE_NONE) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else begin
            send_idle_pct  = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 29 : 0;
            recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 29 : 0;
         end
         send_reading(pick_reading(sb.threshold));
      end
      req_valid = 1'b0;
   endtask

   initial begin
      int directed[$];
      int settings[NUM_PHASES];
      sb = new();
      cycle_count           = 0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_temperature_centi = '0;
      rsp_stall             = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: range edges, truncation, both negative forms, reset threshold
      directed = '{0, 5, 99, 1234, 9999, 10000, 10009, 12599, 12600, 32767, -1, -10, -999,
                   -1000, -1009, -9999, -10000, -32768, 1000, 100, -5432};
      foreach (directed[i]) begin
         send_reading(16'(directed[i]));
      end
      req_valid = 1'b0;

      settings = '{32767, -9999, 0, 10000, 0, 12600, -1, 2500};
      settings[4] = int'($urandom_range(42766)) - 9999;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_threshold(settings[p]);
         run_phase(p % 4, PHASE_BEATS);
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("checked %0d readings over %0d threshold settings, %0d of them error patterns",
               sb.checked, NUM_PHASES + 1, sb.error_patterns);
      $display("idle modes: none, sender, receiver, both; %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### temperature_to_display_digits.f
src/tdd_pkg.sv
src/tdd_split.sv
src/tdd_format.sv
src/temperature_to_display_digits.sv
tb/tb_temperature_to_display_digits.sv
